// ===== rtl/core/msc_pkg.sv =====
// shared types, register codes and constants of the masked byte pattern scanner
package msc_pkg;

  localparam int unsigned MaxPatternDef = 16;
  localparam int unsigned ChunkBytesDef = 4096;

  localparam int unsigned AddrW  = 64;
  localparam int unsigned IndexW = 16;
  localparam int unsigned CareW  = 16;
  localparam int unsigned LenW   = 5;
  localparam int unsigned RegIdxW = 3;

  // register indexes of the configuration port
  localparam logic [RegIdxW-1:0] REG_PATTERN_LOW    = 3'd0;
  localparam logic [RegIdxW-1:0] REG_PATTERN_HIGH   = 3'd1;
  localparam logic [RegIdxW-1:0] REG_CARE_BITS      = 3'd2;
  localparam logic [RegIdxW-1:0] REG_PATTERN_LENGTH = 3'd3;
  localparam logic [RegIdxW-1:0] REG_BASE_ADDRESS   = 3'd4;

  localparam logic [IndexW-1:0] INDEX_MAX = '1;

  typedef struct packed {
    logic [63:0]      pattern_low;
    logic [63:0]      pattern_high;
    logic [CareW-1:0] care_bits;
    logic [LenW-1:0]  pattern_length;
    logic [AddrW-1:0] base_address;
  } cfg_t;

endpackage

// ===== rtl/core/masked_byte_pattern_scanner_top.sv =====
// top level of the masked byte pattern scanner: staging and result registers
// throughput: one word per cycle while the result register is not stalled; the
//   window compare and address add sit between the staging register and the
//   result register
// reset: asynchronous, active low; clears the window, counters and config
//   (pattern length returns to one), and both register stages empty
module masked_byte_pattern_scanner_top
  import msc_pkg::*;
#(
  parameter int unsigned MAX_PATTERN = MaxPatternDef,
  parameter int unsigned CHUNK_BYTES = ChunkBytesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration write channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [RegIdxW-1:0] cfg_index_i,
  input  logic [63:0]        cfg_data_i,
  // input words
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         data_byte_i,
  input  logic               chunk_end_i,
  input  logic               region_end_i,
  // result words
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [AddrW-1:0]   match_address_o,
  output logic [IndexW-1:0]  match_index_o
);

  cfg_t            cfg;
  logic [LenW-1:0] act_len;

  // staging register, holds one accepted word
  logic       stg_valid_q;
  logic [7:0] stg_data_q;
  logic       stg_cend_q;
  logic       stg_rend_q;

  // result register
  logic              res_valid_q;
  logic [AddrW-1:0]  res_addr_q;
  logic [IndexW-1:0] res_idx_q;

  logic              advance;
  logic              step;
  logic              hit;
  logic              emit;
  logic [AddrW-1:0]  addr;
  logic [IndexW-1:0] idx;

  // writes are always taken, the register file never stalls
  assign cfg_ready_o = 1'b1;

  // the result register frees up when empty or being drained
  assign advance    = !res_valid_q || out_ready_i;
  // staged word is processed whenever the result side can move
  assign step       = stg_valid_q && advance;
  // a new word enters while the staged one leaves in the same cycle
  assign in_ready_o = !stg_valid_q || advance;

  msc_cfg #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i && cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg),
    .act_len_o  (act_len)
  );

  msc_match #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_match (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .data_byte_i (stg_data_q),
    .cfg_i       (cfg),
    .act_len_i   (act_len),
    .hit_o       (hit)
  );

  msc_track #(
    .CHUNK_BYTES (CHUNK_BYTES)
  ) u_track (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (step),
    .hit_i           (hit),
    .chunk_end_i     (stg_cend_q),
    .region_end_i    (stg_rend_q),
    .act_len_i       (act_len),
    .base_address_i  (cfg.base_address),
    .emit_o          (emit),
    .match_address_o (addr),
    .match_index_o   (idx)
  );

  // staging register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      stg_valid_q <= in_valid_i;
    end
  end

  // staging payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      stg_data_q <= data_byte_i;
      stg_cend_q <= chunk_end_i;
      stg_rend_q <= region_end_i;
    end
  end

  // result register control: only a word that matched fills it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_addr_q <= addr;
      res_idx_q  <= idx;
    end
  end

  assign out_valid_o     = res_valid_q;
  assign match_address_o = res_addr_q;
  assign match_index_o   = res_idx_q;

endmodule

// ===== rtl/core/msc_cfg.sv =====
// configuration registers and active pattern length
module msc_cfg
  import msc_pkg::*;
#(
  parameter int unsigned MAX_PATTERN = MaxPatternDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_en_i,
  input  logic [RegIdxW-1:0] wr_index_i,
  input  logic [63:0]        wr_data_i,
  output cfg_t               cfg_o,
  output logic [LenW-1:0]    act_len_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{pattern_low:    '0,
                 pattern_high:   '0,
                 care_bits:      '0,
                 pattern_length: LenW'(1),
                 base_address:   '0};
    end else if (wr_en_i) begin
      unique case (wr_index_i)
        REG_PATTERN_LOW:    cfg_q.pattern_low    <= wr_data_i;
        REG_PATTERN_HIGH:   cfg_q.pattern_high   <= wr_data_i;
        REG_CARE_BITS:      cfg_q.care_bits      <= wr_data_i[CareW-1:0];
        REG_PATTERN_LENGTH: cfg_q.pattern_length <= wr_data_i[LenW-1:0];
        REG_BASE_ADDRESS:   cfg_q.base_address   <= wr_data_i;
        default: ;
      endcase
    end
  end

  // zero counts as one, anything beyond the window is clamped
  always_comb begin
    priority if (cfg_q.pattern_length == '0) begin
      act_len_o = LenW'(1);
    end else if (cfg_q.pattern_length > LenW'(MAX_PATTERN)) begin
      act_len_o = LenW'(MAX_PATTERN);
    end else begin
      act_len_o = cfg_q.pattern_length;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/msc_match.sv =====
// byte window shift line and masked pattern compare
module msc_match
  import msc_pkg::*;
#(
  parameter int unsigned MAX_PATTERN = MaxPatternDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  logic [7:0]      data_byte_i,
  input  cfg_t            cfg_i,
  input  logic [LenW-1:0] act_len_i,
  output logic            hit_o
);

  logic [7:0]   win_q [MAX_PATTERN];
  logic [7:0]   win_d [MAX_PATTERN];
  logic [127:0] pat_all;

  assign pat_all = {cfg_i.pattern_high, cfg_i.pattern_low};

  // entry 0 takes the newest byte
  always_comb begin
    win_d[0] = data_byte_i;
    for (int j = 1; j < MAX_PATTERN; j++) begin
      win_d[j] = win_q[j-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < MAX_PATTERN; j++) begin
        win_q[j] <= '0;
      end
    end else if (step_i) begin
      for (int j = 0; j < MAX_PATTERN; j++) begin
        win_q[j] <= win_d[j];
      end
    end
  end

  // pattern byte k lines up with window entry len-1-k
  always_comb begin
    logic [7:0] sel;
    hit_o = 1'b1;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      sel = '0;
      for (int j = 0; j < MAX_PATTERN; j++) begin
        if ({1'b0, act_len_i} == 6'(j + k + 1)) begin
          sel = win_d[j];
        end
      end
      if ((LenW'(k) < act_len_i) && cfg_i.care_bits[k] && (sel != pat_all[8*k +: 8])) begin
        hit_o = 1'b0;
      end
    end
  end

endmodule

// ===== rtl/core/msc_track.sv =====
// chunk position, offset and match count tracking, result address
module msc_track
  import msc_pkg::*;
#(
  parameter int unsigned CHUNK_BYTES = ChunkBytesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic              hit_i,
  input  logic              chunk_end_i,
  input  logic              region_end_i,
  input  logic [LenW-1:0]   act_len_i,
  input  logic [AddrW-1:0]  base_address_i,
  output logic              emit_o,
  output logic [AddrW-1:0]  match_address_o,
  output logic [IndexW-1:0] match_index_o
);

  localparam int unsigned PosW = $clog2(CHUNK_BYTES + 1);

  logic [PosW-1:0]   pos_q, pos_d;
  logic [AddrW-1:0]  off_q, off_d;
  logic              matched_q, matched_d;
  logic [IndexW-1:0] count_q, count_d;

  logic [PosW-1:0] filled;
  logic [PosW-1:0] len_ext;
  logic [PosW-1:0] start;
  logic            close;

  assign filled  = pos_q + PosW'(1);
  assign len_ext = PosW'(act_len_i);
  assign start   = filled - len_ext;
  assign close   = chunk_end_i || region_end_i || (filled >= PosW'(CHUNK_BYTES));

  assign emit_o          = step_i && !matched_q && (filled >= len_ext) && hit_i;
  assign match_address_o = base_address_i + off_q + AddrW'(start);
  assign match_index_o   = count_q;

  always_comb begin
    pos_d     = pos_q;
    off_d     = off_q;
    matched_d = matched_q;
    count_d   = count_q;
    if (step_i) begin
      if (emit_o) begin
        matched_d = 1'b1;
        if (count_q != INDEX_MAX) begin
          count_d = count_q + IndexW'(1);
        end
      end
      if (close) begin
        off_d     = off_q + AddrW'(filled);
        pos_d     = '0;
        matched_d = 1'b0;
      end else begin
        pos_d = filled;
      end
      if (region_end_i) begin
        off_d   = '0;
        count_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      off_q     <= '0;
      matched_q <= 1'b0;
      count_q   <= '0;
    end else begin
      pos_q     <= pos_d;
      off_q     <= off_d;
      matched_q <= matched_d;
      count_q   <= count_d;
    end
  end

endmodule

// ===== rtl/core/msc_checker.sv =====
// port level checker for the scanner top, attached by bind
module msc_checker
  import msc_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               cfg_valid_i,
  input logic               cfg_ready_o,
  input logic [RegIdxW-1:0] cfg_index_i,
  input logic [63:0]        cfg_data_i,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic [7:0]         data_byte_i,
  input logic               chunk_end_i,
  input logic               region_end_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [AddrW-1:0]   match_address_o,
  input logic [IndexW-1:0]  match_index_o
);

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(match_address_o)
      && $stable(match_index_o))
  else $error("result word changed while stalled");

  // the input side stalls only behind a blocked result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
  else $error("input stalled without a blocked result");

  // a new result follows an accepted word through the staging and result registers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
  else $error("result without a word accepted two cycles earlier");

  // configuration writes are never refused
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
  else $error("configuration write stalled");

endmodule

bind masked_byte_pattern_scanner_top msc_checker u_msc_checker (.*);

// ===== tb/testbench.sv =====
// self-checking testbench of the masked byte pattern scanner with its own scan predictor
module testbench;
  import msc_pkg::*;

  // run shape
  localparam int unsigned MAX_PAT         = MaxPatternDef;
  localparam int unsigned CHUNK_LIMIT     = ChunkBytesDef;
  localparam int unsigned RANDOM_ITEMS    = 1725;
  localparam int unsigned TAIL_ITEMS      = 200;
  localparam int unsigned PRESSURE_ITEMS  = 400;
  localparam int unsigned RX_HOLD_CYCLES  = 300;
  localparam int unsigned SETTLE_CYCLES   = 6;
  localparam int unsigned WATCHDOG_CYCLES = 3_000_000;
  localparam int unsigned ERR_SHOWN       = 10;

  // index beyond the register file, writes to it must be dropped
  localparam logic [RegIdxW-1:0] REG_SPARE = 3'd7;

  typedef struct packed {
    logic [AddrW-1:0]  addr;
    logic [IndexW-1:0] idx;
  } hit_t;

  // directed script: register writes and bytes, some with the match typed in
  typedef enum logic {ROW_REG, ROW_BYTE} row_kind_e;
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_HIT} row_chk_e;

  typedef struct {
    row_kind_e          kind;
    logic [RegIdxW-1:0] reg_idx;
    logic [63:0]        reg_data;
    logic [7:0]         data;
    logic               ce;
    logic               re;
    row_chk_e           chk;
    logic [AddrW-1:0]   addr;
    logic [IndexW-1:0]  idx;
  } row_t;

  row_t script_rows [] = '{
    // after reset: length one, no care bits, so each chunk matches on its first byte
    '{ROW_BYTE, '0, '0, 8'h00, 1'b0, 1'b0, CHK_HIT,  64'h0, 16'd0},
    '{ROW_BYTE, '0, '0, 8'hFF, 1'b1, 1'b0, CHK_NONE, '0, '0},
    '{ROW_BYTE, '0, '0, 8'h5A, 1'b0, 1'b1, CHK_HIT,  64'h2, 16'd1},
    // unknown index ignored, then a base just below the top of the address space
    '{ROW_REG, REG_SPARE,          '1,                    '0, 1'b0, 1'b0, CHK_NONE, '0, '0},
    '{ROW_REG, REG_BASE_ADDRESS,   64'hFFFF_FFFF_FFFF_FFFE, '0, 1'b0, 1'b0, CHK_NONE, '0, '0},
    '{ROW_REG, REG_PATTERN_LOW,    64'h0000_0000_0000_00FF, '0, 1'b0, 1'b0, CHK_NONE, '0, '0},
    '{ROW_REG, REG_CARE_BITS,      64'h1,                 '0, 1'b0, 1'b0, CHK_NONE, '0, '0},
    // length zero behaves as one
    '{ROW_REG, REG_PATTERN_LENGTH, 64'h0,                 '0, 1'b0, 1'b0, CHK_NONE, '0, '0},
    '{ROW_BYTE, '0, '0, 8'hFF, 1'b0, 1'b0, CHK_HIT,  64'hFFFF_FFFF_FFFF_FFFE, 16'd0},
    '{ROW_BYTE, '0, '0, 8'hFF, 1'b1, 1'b0, CHK_NONE, '0, '0},
    // address wraps to zero
    '{ROW_BYTE, '0, '0, 8'hFF, 1'b0, 1'b0, CHK_HIT,  64'h0, 16'd1},
    '{ROW_BYTE, '0, '0, 8'h00, 1'b0, 1'b1, CHK_NONE, '0, '0},
    // full sixteen byte pattern, every byte cared for, length above range clamps
    '{ROW_REG, REG_PATTERN_LOW,    64'h0706_0504_0302_0100, '0, 1'b0, 1'b0, CHK_NONE, '0, '0},
    '{ROW_REG, REG_PATTERN_HIGH,   64'h0F0E_0D0C_0B0A_0908, '0, 1'b0, 1'b0, CHK_NONE, '0, '0},
    '{ROW_REG, REG_CARE_BITS,      64'hFFFF,              '0, 1'b0, 1'b0, CHK_NONE, '0, '0},
    '{ROW_REG, REG_PATTERN_LENGTH, 64'd31,                '0, 1'b0, 1'b0, CHK_NONE, '0, '0},
    '{ROW_REG, REG_BASE_ADDRESS,   64'h0,                 '0, 1'b0, 1'b0, CHK_NONE, '0, '0},
    '{ROW_BYTE, '0, '0, 8'h00, 1'b0, 1'b0, CHK_MODEL, '0, '0},
    '{ROW_BYTE, '0, '0, 8'h01, 1'b0, 1'b0, CHK_MODEL, '0, '0},
    '{ROW_BYTE, '0, '0, 8'h02, 1'b0, 1'b0, CHK_MODEL, '0, '0},
    '{ROW_BYTE, '0, '0, 8'h03, 1'b0, 1'b0, CHK_MODEL, '0, '0},
    '{ROW_BYTE, '0, '0, 8'h04, 1'b0, 1'b0, CHK_MODEL, '0, '0},
    '{ROW_BYTE, '0, '0, 8'h05, 1'b0, 1'b0, CHK_MODEL, '0, '0},
    '{ROW_BYTE, '0, '0, 8'h06, 1'b0, 1'b0, CHK_MODEL, '0, '0},
    '{ROW_BYTE, '0, '0, 8'h07, 1'b0, 1'b0, CHK_MODEL, '0, '0},
    '{ROW_BYTE, '0, '0, 8'h08, 1'b0, 1'b0, CHK_MODEL, '0, '0},
    '{ROW_BYTE, '0, '0, 8'h09, 1'b0, 1'b0, CHK_MODEL, '0, '0},
    '{ROW_BYTE, '0, '0, 8'h0A, 1'b0, 1'b0, CHK_MODEL, '0, '0},
    '{ROW_BYTE, '0, '0, 8'h0B, 1'b0, 1'b0, CHK_MODEL, '0, '0},
    '{ROW_BYTE, '0, '0, 8'h0C, 1'b0, 1'b0, CHK_MODEL, '0, '0},
    '{ROW_BYTE, '0, '0, 8'h0D, 1'b0, 1'b0, CHK_MODEL, '0, '0},
    '{ROW_BYTE, '0, '0, 8'h0E, 1'b0, 1'b0, CHK_MODEL, '0, '0},
    '{ROW_BYTE, '0, '0, 8'h0F, 1'b0, 1'b1, CHK_HIT,  64'h0, 16'd0},
    // short chunk: too few bytes, and the old window byte must not be used
    '{ROW_REG, REG_PATTERN_LENGTH, 64'd2,                 '0, 1'b0, 1'b0, CHK_NONE, '0, '0},
    '{ROW_REG, REG_CARE_BITS,      64'h3,                 '0, 1'b0, 1'b0, CHK_NONE, '0, '0},
    '{ROW_BYTE, '0, '0, 8'h00, 1'b1, 1'b0, CHK_NONE, '0, '0},
    '{ROW_BYTE, '0, '0, 8'h01, 1'b0, 1'b1, CHK_NONE, '0, '0}
  };

  // dut ports
  logic               clk;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [RegIdxW-1:0] cfg_index_i;
  logic [63:0]        cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [7:0]         data_byte_i;
  logic               chunk_end_i;
  logic               region_end_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [AddrW-1:0]   match_address_o;
  logic [IndexW-1:0]  match_index_o;

  // predictor copy of the registers
  logic [127:0]      pat_q;
  logic [CareW-1:0]  care_q;
  logic [LenW-1:0]   len_q;
  logic [AddrW-1:0]  base_q;

  // predictor copy of the scan state
  logic [7:0]        win_q [16];
  int unsigned       chunk_fill;
  logic [AddrW-1:0]  chunk_off;
  bit                chunk_hit;
  logic [IndexW-1:0] hit_count;

  // matches still owed by the block, oldest first
  hit_t due_matches [$];

  // idling and pressure knobs of the sender and the receiver
  bit          idle_tx;
  bit          idle_rx;
  bit          hold_req;
  int unsigned hold_left;
  int unsigned stall_left;

  // bookkeeping
  int unsigned err_count;
  int unsigned bytes_fed;
  int unsigned matches_seen;
  int unsigned reg_writes;
  int unsigned settings_used;

  masked_byte_pattern_scanner_top dut (
    .clk_i           (clk),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .data_byte_i     (data_byte_i),
    .chunk_end_i     (chunk_end_i),
    .region_end_i    (region_end_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .match_address_o (match_address_o),
    .match_index_o   (match_index_o)
  );

  // clock, period of four
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // hard stop in case the block hangs
  initial begin
    #(WATCHDOG_CYCLES * 4);
    $display("timeout after %0d cycles, %0d matches still owed", WATCHDOG_CYCLES,
             due_matches.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic flag_error(input string what);
    err_count++;
    if (err_count <= ERR_SHOWN) begin
      $display("error: %s", what);
    end
  endtask

  // pattern length as the block uses it: zero means one, clamp at the window size
  function automatic int unsigned eff_len();
    if (len_q == '0) begin
      return 1;
    end
    if (len_q > MAX_PAT) begin
      return MAX_PAT;
    end
    return int'(len_q);
  endfunction

  function automatic logic [7:0] pat_byte(input int unsigned k);
    return pat_q[8*k +: 8];
  endfunction

  task automatic apply_cfg(input logic [RegIdxW-1:0] idx, input logic [63:0] val);
    case (idx)
      REG_PATTERN_LOW:    pat_q[63:0]   = val;
      REG_PATTERN_HIGH:   pat_q[127:64] = val;
      REG_CARE_BITS:      care_q        = val[CareW-1:0];
      REG_PATTERN_LENGTH: len_q         = val[LenW-1:0];
      REG_BASE_ADDRESS:   base_q        = val;
      default: ;
    endcase
  endtask

  // advances the scan state by one byte, returns whether it completes a first match
  function automatic bit scan_byte(input logic [7:0] d, input logic ce, input logic re,
                                   output hit_t h);
    int unsigned len;
    int unsigned filled;
    bit          hit;
    bit          same;
    len = eff_len();
    hit = 1'b0;
    h   = '0;
    for (int i = 15; i > 0; i--) begin
      win_q[i] = win_q[i-1];
    end
    win_q[0] = d;
    filled = chunk_fill + 1;
    if (!chunk_hit && filled >= len) begin
      same = 1'b1;
      // pattern byte 0 lines up with the oldest byte of the window slice
      for (int k = 0; k < len; k++) begin
        if (care_q[k] && win_q[len-1-k] != pat_byte(k)) begin
          same = 1'b0;
        end
      end
      if (same) begin
        hit    = 1'b1;
        h.addr = base_q + chunk_off + 64'(filled - len);
        h.idx  = hit_count;
        if (hit_count != INDEX_MAX) begin
          hit_count++;
        end
        chunk_hit = 1'b1;
      end
    end
    if (ce || re || filled >= CHUNK_LIMIT) begin
      chunk_off  = chunk_off + 64'(filled);
      chunk_fill = 0;
      chunk_hit  = 1'b0;
    end else begin
      chunk_fill = filled;
    end
    if (re) begin
      chunk_off = '0;
      hit_count = '0;
    end
    return hit;
  endfunction

  // offers one byte, waits for the handshake and books what it should produce
  task automatic send_byte(input logic [7:0] d, input logic ce, input logic re,
                           input row_chk_e chk, input hit_t typed);
    hit_t h;
    bit   hit;
    if (idle_tx && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_valid_i   <= 1'b1;
    data_byte_i  <= d;
    chunk_end_i  <= ce;
    region_end_i <= re;
    do @(posedge clk); while (!in_ready_o);
    hit = scan_byte(d, ce, re, h);
    case (chk)
      CHK_MODEL: if (hit) due_matches.push_back(h);
      CHK_HIT:   due_matches.push_back(typed);
      default: ;
    endcase
    bytes_fed++;
    @(negedge clk);
  endtask

  task automatic cfg_write(input logic [RegIdxW-1:0] idx, input logic [63:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk); while (!cfg_ready_o);
    apply_cfg(idx, val);
    reg_writes++;
    @(negedge clk);
  endtask

  // stop offering bytes and wait until the block has nothing left in flight
  task automatic settle_block();
    in_valid_i <= 1'b0;
    while (due_matches.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_config(input logic [63:0] lo, input logic [63:0] hi,
                            input logic [63:0] care, input logic [63:0] len,
                            input logic [63:0] base);
    settle_block();
    cfg_write(REG_PATTERN_LOW, lo);
    cfg_write(REG_PATTERN_HIGH, hi);
    cfg_write(REG_CARE_BITS, care);
    cfg_write(REG_PATTERN_LENGTH, len);
    cfg_write(REG_BASE_ADDRESS, base);
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  // one random setting and a stream of bytes under it
  task automatic run_phase(input int unsigned n, input bit pressured, input bit quiet);
    logic [7:0]  pend [$];
    logic [63:0] care;
    logic [63:0] len;
    logic [63:0] base;
    int unsigned chunk_gap;
    int unsigned region_gap;
    int unsigned plen;
    logic [7:0]  b;
    logic        ce;
    logic        re;
    hit_t        none;
    none = '0;
    len  = {$urandom, $urandom};
    care = {$urandom, $urandom};
    if ($urandom_range(0, 1) == 0) begin
      len[63:LenW]    = '0;
      care[63:CareW]  = '0;
    end
    case ($urandom_range(0, 7))
      0:       len[LenW-1:0] = '0;
      1:       len[LenW-1:0] = LenW'(MAX_PAT);
      2:       len[LenW-1:0] = LenW'($urandom_range(MAX_PAT + 1, 31));
      3:       len[LenW-1:0] = LenW'($urandom_range(7, MAX_PAT - 1));
      default: len[LenW-1:0] = LenW'($urandom_range(1, 6));
    endcase
    case ($urandom_range(0, 3))
      0:       care[CareW-1:0] = '1;
      1:       care[CareW-1:0] = '0;
      2:       care[CareW-1:0] = CareW'($urandom);
      default: care[CareW-1:0] = CareW'($urandom | $urandom);
    endcase
    case ($urandom_range(0, 3))
      0:       base = '0;
      1:       base = '1 - 64'($urandom_range(0, 50));
      default: base = {$urandom, $urandom};
    endcase
    chunk_gap  = $urandom_range(3, 40);
    region_gap = $urandom_range(40, 300);
    if (pressured) begin
      // every chunk matches on its first byte, so results pile up behind the hold
      len        = 64'd1;
      care       = '0;
      chunk_gap  = 3;
    end
    set_config({$urandom, $urandom}, {$urandom, $urandom}, care, len, base);
    plen    = eff_len();
    idle_tx = (pressured || quiet) ? 1'b0 : ($urandom_range(0, 3) != 0);
    idle_rx = quiet ? 1'b0 : ($urandom_range(0, 3) != 0);
    if (pressured) begin
      hold_req = 1'b1;
    end
    for (int unsigned i = 0; i < n; i++) begin
      if (pend.size() == 0) begin
        if ($urandom_range(0, 9) < 5) begin
          // well-formed occurrence, wildcard positions get random bytes
          for (int unsigned k = 0; k < plen; k++) begin
            pend.push_back(care_q[k] ? pat_byte(k) : 8'($urandom));
          end
        end else begin
          // noise, partly built from pattern bytes for near misses
          repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(0, 3) == 0) begin
              pend.push_back(pat_byte($urandom_range(0, plen - 1)));
            end else begin
              pend.push_back(8'($urandom));
            end
          end
        end
      end
      b  = pend.pop_front();
      ce = $urandom_range(1, chunk_gap) == 1;
      re = $urandom_range(1, region_gap) == 1;
      send_byte(b, ce, re, CHK_MODEL, none);
    end
  endtask

  // result side: random stalls in bursts, plus one long hold on request
  initial begin
    out_ready_i = 1'b0;
    hold_left   = 0;
    stall_left  = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = RX_HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else if (stall_left != 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else if (idle_rx && $urandom_range(0, 6) == 0) begin
        out_ready_i <= 1'b0;
        stall_left = $urandom_range(0, 10);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // result check against the oldest owed match
  always @(posedge clk) begin
    hit_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      matches_seen++;
      if (due_matches.size() == 0) begin
        flag_error($sformatf("unexpected match addr %h index %0d",
                             match_address_o, match_index_o));
      end else begin
        want = due_matches.pop_front();
        if (match_address_o !== want.addr) begin
          flag_error($sformatf("match %0d address: expected %h, got %h",
                               matches_seen, want.addr, match_address_o));
        end
        if (match_index_o !== want.idx) begin
          flag_error($sformatf("match %0d index: expected %0d, got %0d",
                               matches_seen, want.idx, match_index_o));
        end
      end
    end
  end

  // stimulus and verdict
  initial begin
    int unsigned random_fed;
    int unsigned n;
    bit          cfg_open;
    hit_t        typed;

    // known values on every input from time zero
    rst_ni       = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = '0;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    data_byte_i  = '0;
    chunk_end_i  = 1'b0;
    region_end_i = 1'b0;
    idle_tx      = 1'b1;
    idle_rx      = 1'b1;
    hold_req     = 1'b0;
    err_count    = 0;
    bytes_fed    = 0;
    matches_seen = 0;
    reg_writes   = 0;
    settings_used = 1;

    // predictor reset state mirrors the block's
    pat_q      = '0;
    care_q     = '0;
    len_q      = LenW'(1);
    base_q     = '0;
    chunk_fill = 0;
    chunk_off  = '0;
    chunk_hit  = 1'b0;
    hit_count  = '0;
    foreach (win_q[i]) win_q[i] = '0;

    repeat (11) @(negedge clk);
    rst_ni <= 1'b1;
    @(negedge clk);

    // directed script, register rows only ever land on an idle block
    cfg_open = 1'b0;
    foreach (script_rows[r]) begin
      if (script_rows[r].kind == ROW_REG) begin
        if (!cfg_open) begin
          settle_block();
          cfg_open = 1'b1;
          settings_used++;
        end
        cfg_write(script_rows[r].reg_idx, script_rows[r].reg_data);
      end else begin
        if (cfg_open) begin
          cfg_valid_i <= 1'b0;
          cfg_open = 1'b0;
        end
        typed.addr = script_rows[r].addr;
        typed.idx  = script_rows[r].idx;
        send_byte(script_rows[r].data, script_rows[r].ce, script_rows[r].re,
                  script_rows[r].chk, typed);
      end
    end
    if (cfg_open) begin
      cfg_valid_i <= 1'b0;
    end

    // random settings, the first one under a long result hold
    random_fed = 0;
    run_phase(PRESSURE_ITEMS, 1'b1, 1'b0);
    random_fed += PRESSURE_ITEMS;
    while (random_fed < RANDOM_ITEMS) begin
      n = $urandom_range(60, 240);
      if (n > RANDOM_ITEMS - random_fed) begin
        n = RANDOM_ITEMS - random_fed;
      end
      run_phase(n, 1'b0, 1'b0);
      random_fed += n;
    end

    // last part without idling on either side
    run_phase(TAIL_ITEMS, 1'b0, 1'b1);

    settle_block();
    repeat (4 * SETTLE_CYCLES) @(negedge clk);
    if (due_matches.size() != 0) begin
      flag_error($sformatf("%0d matches never arrived", due_matches.size()));
    end

    $display("covered %0d bytes under %0d register settings (%0d writes), %0d matches checked",
             bytes_fed, settings_used, reg_writes, matches_seen);
    $display("took in a long result hold, address wrap, length clamps and short chunks, %0d errors",
             err_count);
    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
